>>> sv/hsl_pkg.sv
// ----------------------------------------------------------------------------
// hsl_pkg
// Shared widths, constants, types and helpers for the HSL to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsl_pkg;

	// Channel width; saturation, lightness and channels use 2^CHANNEL_BITS - 1 as one
	localparam int CHANNEL_BITS = 16;
	localparam int CH_W         = CHANNEL_BITS;

	// Port field widths
	localparam int FIELD_W = 16;
	localparam int HUE_W   = 16;

	// Hue geometry, degrees * 64
	localparam logic [HUE_W-1:0] HUE_SECTOR = 16'd3840;
	localparam logic [HUE_W-1:0] HUE_TURN   = 16'd23040;

	// Position within a sector pair folded to 0..3840
	localparam int W_W = 12;

	// x = (c*w + 1920) / 3840 = ((c*w + 1920) >> 8) / 15
	localparam int X_BIAS    = 1920;
	localparam int X_SHIFT   = 8;
	localparam int X_DIV_W   = 4;
	localparam int X_DIV     = (1 << X_DIV_W) - 1;
	localparam int CW_W      = CH_W + W_W;
	localparam int Z_W       = CH_W + X_DIV_W;
	localparam int RX_W      = X_DIV_W + 1;
	localparam longint RECIP = (longint'(1) << Z_W) / X_DIV;

	localparam logic [CH_W-1:0] FULL       = {CH_W{1'b1}};
	localparam logic [CH_W:0]   RECIP_V    = (CH_W+1)'(RECIP);
	localparam logic [CW_W:0]   X_BIAS_V   = (CW_W+1)'(X_BIAS);
	localparam logic [RX_W-1:0] X_DIV_V    = RX_W'(X_DIV);

	// Input beat to result beat, in cycles
	localparam int LATENCY = 13;

	typedef enum logic [2:0] {
		SEC_RED_YELLOW   = 3'd0,
		SEC_YELLOW_GREEN = 3'd1,
		SEC_GREEN_CYAN   = 3'd2,
		SEC_CYAN_BLUE    = 3'd3,
		SEC_BLUE_MAGENTA = 3'd4,
		SEC_MAGENTA_RED  = 3'd5
	} hsl_sector_t;

	// Per-beat side data that rides along the pipeline
	typedef struct packed {
		logic        ok;
		hsl_sector_t sector;
		logic [CH_W:0] two_l;
	} hsl_meta_t;

	function automatic logic [CH_W-1:0] clamp_frac(input logic [FIELD_W-1:0] v);
		logic [31:0] v_ext;
		v_ext = 32'(v);
		if (v_ext > 32'(FULL)) begin
			return FULL;
		end
		return CH_W'(v);
	endfunction

	function automatic logic [CH_W-1:0] sat_chan(input logic [CH_W+2:0] v);
		if (v > (CH_W+3)'(FULL)) begin
			return FULL;
		end
		return v[CH_W-1:0];
	endfunction

	function automatic logic [FIELD_W-1:0] to_field(input logic [CH_W-1:0] v);
		return FIELD_W'(v);
	endfunction

endpackage

`default_nettype wire

>>> sv/hsl_chroma.sv
// ----------------------------------------------------------------------------
// hsl_chroma
// Stages 1-6: input clamp, hue sector and fold, chroma c = round(t*s / FULL).
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_chroma (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                vld_i,
	input  wire logic [hsl_pkg::HUE_W-1:0]           hue,
	input  wire logic [hsl_pkg::FIELD_W-1:0]         saturation,
	input  wire logic [hsl_pkg::FIELD_W-1:0]         lightness,
	output logic                                     vld_o,
	output hsl_pkg::hsl_meta_t                       meta_o,
	output logic [hsl_pkg::CH_W-1:0]                 c_o,
	output logic [hsl_pkg::W_W-1:0]                  w_o
);

	localparam int CW  = hsl_pkg::CH_W;
	localparam int PW  = 2 * CW;
	localparam int RW  = 2 * CW + 2;

	// stage 1
	logic [CW:0]               two_l;
	logic [CW:0]               full_x;
	logic [CW:0]               l_dev;
	logic [CW-1:0]             sat_c;
	hsl_pkg::hsl_sector_t      sector;
	logic                      vld_s1;
	hsl_pkg::hsl_meta_t        meta_s1;
	logic [hsl_pkg::HUE_W-1:0] hue_s1;
	logic [CW-1:0]             sat_s1;
	logic [CW-1:0]             t_s1;

	// stage 2
	logic [hsl_pkg::HUE_W-1:0] lo_b;
	logic [hsl_pkg::HUE_W-1:0] hi_b;
	logic [hsl_pkg::HUE_W-1:0] w_full;
	logic                      vld_s2;
	hsl_pkg::hsl_meta_t        meta_s2;
	logic [PW-1:0]             p_s2;
	logic [hsl_pkg::W_W-1:0]   w_s2;

	// stages 3-6
	logic [PW:0]               qsum;
	logic [RW-1:0]             r_full;
	logic [CW:0]               c_full;
	logic                      vld_s3, vld_s4, vld_s5, vld_s6;
	hsl_pkg::hsl_meta_t        meta_s3, meta_s4, meta_s5, meta_s6;
	logic [hsl_pkg::W_W-1:0]   w_s3, w_s4, w_s5, w_s6;
	logic [PW-1:0]             y_s3, y_s4;
	logic [CW:0]               q1_s4, q1_s5;
	logic [CW:0]               r_s5;
	logic [CW-1:0]             c_s6;

	always_comb begin
		two_l  = {hsl_pkg::clamp_frac(lightness), 1'b0};
		sat_c  = hsl_pkg::clamp_frac(saturation);
		full_x = {1'b0, hsl_pkg::FULL};
		l_dev  = (two_l >= full_x) ? (two_l - full_x) : (full_x - two_l);
		priority if (hue < hsl_pkg::HUE_SECTOR) begin
			sector = hsl_pkg::SEC_RED_YELLOW;
		end else if (hue < 16'd7680) begin
			sector = hsl_pkg::SEC_YELLOW_GREEN;
		end else if (hue < 16'd11520) begin
			sector = hsl_pkg::SEC_GREEN_CYAN;
		end else if (hue < 16'd15360) begin
			sector = hsl_pkg::SEC_CYAN_BLUE;
		end else if (hue < 16'd19200) begin
			sector = hsl_pkg::SEC_BLUE_MAGENTA;
		end else if (hue < hsl_pkg::HUE_TURN) begin
			sector = hsl_pkg::SEC_MAGENTA_RED;
		end else begin
			sector = hsl_pkg::SEC_RED_YELLOW;
		end
	end

	// fold hue into 0..3840: rising edge in even sectors, falling in odd
	always_comb begin
		lo_b   = hsl_pkg::HUE_W'(meta_s1.sector) * hsl_pkg::HUE_SECTOR;
		hi_b   = lo_b + hsl_pkg::HUE_SECTOR;
		w_full = meta_s1.sector[0] ? (hi_b - hue_s1) : (hue_s1 - lo_b);
	end

	// y / FULL: estimate (y + y>>CW) >> CW is low by at most one
	always_comb begin
		qsum   = {1'b0, y_s3} + (PW+1)'(y_s3 >> CW);
		r_full = RW'(y_s4) - RW'({q1_s4, {CW{1'b0}}}) + RW'(q1_s4);
		c_full = (r_s5 >= {1'b0, hsl_pkg::FULL}) ? (q1_s5 + 1'b1) : q1_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		meta_s1.ok     <= (hue < hsl_pkg::HUE_TURN);
		meta_s1.sector <= sector;
		meta_s1.two_l  <= two_l;
		hue_s1         <= hue;
		sat_s1         <= sat_c;
		t_s1           <= hsl_pkg::FULL - l_dev[CW-1:0];

		meta_s2 <= meta_s1;
		p_s2    <= PW'(t_s1) * PW'(sat_s1);
		w_s2    <= w_full[hsl_pkg::W_W-1:0];

		meta_s3 <= meta_s2;
		w_s3    <= w_s2;
		y_s3    <= p_s2 + PW'(hsl_pkg::FULL >> 1);

		meta_s4 <= meta_s3;
		w_s4    <= w_s3;
		y_s4    <= y_s3;
		q1_s4   <= qsum[PW:CW];

		meta_s5 <= meta_s4;
		w_s5    <= w_s4;
		q1_s5   <= q1_s4;
		r_s5    <= r_full[CW:0];

		meta_s6 <= meta_s5;
		w_s6    <= w_s5;
		c_s6    <= c_full[CW-1:0];
	end

	assign vld_o  = vld_s6;
	assign meta_o = meta_s6;
	assign c_o    = c_s6;
	assign w_o    = w_s6;

endmodule

`default_nettype wire

>>> sv/hsl_hue_mix.sv
// ----------------------------------------------------------------------------
// hsl_hue_mix
// Stages 7-11: secondary component x = round(c*w / 3840).
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_hue_mix (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        vld_i,
	input  wire hsl_pkg::hsl_meta_t          meta_i,
	input  wire logic [hsl_pkg::CH_W-1:0]    c_i,
	input  wire logic [hsl_pkg::W_W-1:0]     w_i,
	output logic                             vld_o,
	output hsl_pkg::hsl_meta_t               meta_o,
	output logic [hsl_pkg::CH_W-1:0]         c_o,
	output logic [hsl_pkg::CH_W-1:0]         x_o
);

	localparam int CW  = hsl_pkg::CH_W;
	localparam int CWW = hsl_pkg::CW_W;
	localparam int ZW  = hsl_pkg::Z_W;
	localparam int KW  = ZW + CW + 1;
	localparam int RXW = hsl_pkg::RX_W;

	logic [CWW:0]             zsum;
	logic [CW:0]              q1x;
	logic [ZW:0]              rx_full;
	logic [CW:0]              x_full;

	logic                     vld_s7, vld_s8, vld_s9, vld_s10, vld_s11;
	hsl_pkg::hsl_meta_t       meta_s7, meta_s8, meta_s9, meta_s10, meta_s11;
	logic [CW-1:0]            c_s7, c_s8, c_s9, c_s10, c_s11;
	logic [CWW-1:0]           cw_s7;
	logic [ZW-1:0]            z_s8, z_s9;
	logic [KW-1:0]            zk_s9;
	logic [CW:0]              q1x_s10;
	logic [RXW-1:0]           rx_s10;
	logic [CW-1:0]            x_s11;

	// z / 15 via reciprocal; estimate is exact or one low
	always_comb begin
		zsum    = {1'b0, cw_s7} + hsl_pkg::X_BIAS_V;
		q1x     = zk_s9[ZW +: CW+1];
		rx_full = (ZW+1)'(z_s9) - ((ZW+1)'(q1x) << hsl_pkg::X_DIV_W) + (ZW+1)'(q1x);
		x_full  = (rx_s10 >= hsl_pkg::X_DIV_V) ? (q1x_s10 + 1'b1) : q1x_s10;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else begin
			vld_s7  <= vld_i;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		meta_s7 <= meta_i;
		c_s7    <= c_i;
		cw_s7   <= CWW'(c_i) * CWW'(w_i);

		meta_s8 <= meta_s7;
		c_s8    <= c_s7;
		z_s8    <= zsum[hsl_pkg::X_SHIFT +: ZW];

		meta_s9 <= meta_s8;
		c_s9    <= c_s8;
		z_s9    <= z_s8;
		zk_s9   <= KW'(z_s8) * KW'(hsl_pkg::RECIP_V);

		meta_s10 <= meta_s9;
		c_s10    <= c_s9;
		q1x_s10  <= q1x;
		rx_s10   <= rx_full[RXW-1:0];

		meta_s11 <= meta_s10;
		c_s11    <= c_s10;
		x_s11    <= x_full[CW-1:0];
	end

	assign vld_o  = vld_s11;
	assign meta_o = meta_s11;
	assign c_o    = c_s11;
	assign x_o    = x_s11;

endmodule

`default_nettype wire

>>> sv/hsl_assemble.sv
// ----------------------------------------------------------------------------
// hsl_assemble
// Stages 12-13: m, c+m, x+m with clamp, sector ordering, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_assemble (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          vld_i,
	input  wire hsl_pkg::hsl_meta_t            meta_i,
	input  wire logic [hsl_pkg::CH_W-1:0]      c_i,
	input  wire logic [hsl_pkg::CH_W-1:0]      x_i,
	output logic                               done,
	output logic                               valid_res,
	output logic [hsl_pkg::FIELD_W-1:0]        red,
	output logic [hsl_pkg::FIELD_W-1:0]        green,
	output logic [hsl_pkg::FIELD_W-1:0]        blue
);

	localparam int CW = hsl_pkg::CH_W;
	localparam int SW = CW + 3;

	logic [CW:0]                 base;
	logic [SW-1:0]               lo_sum, chi_sum, xm_sum;
	logic [CW-1:0]               r_n, g_n, b_n;

	logic                        vld_s12, vld_s13;
	logic                        ok_s12;
	hsl_pkg::hsl_sector_t        sector_s12;
	logic [CW-1:0]               lo_s12, chi_s12, xm_s12;
	logic                        ok_s13;
	logic [hsl_pkg::FIELD_W-1:0] red_s13, green_s13, blue_s13;

	always_comb begin
		base    = (meta_i.two_l >= {1'b0, c_i}) ? (meta_i.two_l - {1'b0, c_i}) : '0;
		lo_sum  = (SW'(base) + SW'(1)) >> 1;
		chi_sum = (SW'(meta_i.two_l) + SW'(c_i) + SW'(1)) >> 1;
		xm_sum  = (SW'(base) + (SW'(x_i) << 1) + SW'(1)) >> 1;
	end

	always_comb begin
		unique case (sector_s12)
			hsl_pkg::SEC_RED_YELLOW: begin
				r_n = chi_s12; g_n = xm_s12;  b_n = lo_s12;
			end
			hsl_pkg::SEC_YELLOW_GREEN: begin
				r_n = xm_s12;  g_n = chi_s12; b_n = lo_s12;
			end
			hsl_pkg::SEC_GREEN_CYAN: begin
				r_n = lo_s12;  g_n = chi_s12; b_n = xm_s12;
			end
			hsl_pkg::SEC_CYAN_BLUE: begin
				r_n = lo_s12;  g_n = xm_s12;  b_n = chi_s12;
			end
			hsl_pkg::SEC_BLUE_MAGENTA: begin
				r_n = xm_s12;  g_n = lo_s12;  b_n = chi_s12;
			end
			hsl_pkg::SEC_MAGENTA_RED: begin
				r_n = chi_s12; g_n = lo_s12;  b_n = xm_s12;
			end
			default: begin
				r_n = '0;      g_n = '0;      b_n = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
		end else begin
			vld_s12 <= vld_i;
			vld_s13 <= vld_s12;
		end
	end

	always_ff @(posedge clk) begin
		ok_s12     <= meta_i.ok;
		sector_s12 <= meta_i.sector;
		lo_s12     <= hsl_pkg::sat_chan(lo_sum);
		chi_s12    <= hsl_pkg::sat_chan(chi_sum);
		xm_s12     <= hsl_pkg::sat_chan(xm_sum);

		// out-of-range hue reports all channels as zero
		ok_s13    <= ok_s12;
		red_s13   <= ok_s12 ? hsl_pkg::to_field(r_n) : '0;
		green_s13 <= ok_s12 ? hsl_pkg::to_field(g_n) : '0;
		blue_s13  <= ok_s12 ? hsl_pkg::to_field(b_n) : '0;
	end

	assign done      = vld_s13;
	assign valid_res = ok_s13;
	assign red       = red_s13;
	assign green     = green_s13;
	assign blue      = blue_s13;

endmodule

`default_nettype wire

>>> sv/hsl_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// HSL pixel to RGB, fully pipelined, one pixel per clock.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------
//  pixel in | start, busy (beat at | hue, saturation, lightness
//           | start & !busy)       |
//  result   | done (one cycle)     | valid_res, red, green, blue
//
//  An accepted beat reaches its done strobe through the 13-stage register
//  pipeline; one beat is taken every cycle.
//  busy is held low: the pipeline always advances and results are never held.
//  arst_n clears the valid bits of every stage; no beat is in flight after it.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_to_rgb_converter (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [hsl_pkg::HUE_W-1:0]     hue,
	input  wire logic [hsl_pkg::FIELD_W-1:0]   saturation,
	input  wire logic [hsl_pkg::FIELD_W-1:0]   lightness,
	output logic                               done,
	output logic                               valid_res,
	output logic [hsl_pkg::FIELD_W-1:0]        red,
	output logic [hsl_pkg::FIELD_W-1:0]        green,
	output logic [hsl_pkg::FIELD_W-1:0]        blue
);

	logic                          chr_vld;
	hsl_pkg::hsl_meta_t            chr_meta;
	logic [hsl_pkg::CH_W-1:0]      chr_c;
	logic [hsl_pkg::W_W-1:0]       chr_w;

	logic                          mix_vld;
	hsl_pkg::hsl_meta_t            mix_meta;
	logic [hsl_pkg::CH_W-1:0]      mix_c;
	logic [hsl_pkg::CH_W-1:0]      mix_x;

	assign busy = 1'b0;

	hsl_chroma u_chroma (
		.clk        (clk),
		.arst_n     (arst_n),
		.vld_i      (start),
		.hue        (hue),
		.saturation (saturation),
		.lightness  (lightness),
		.vld_o      (chr_vld),
		.meta_o     (chr_meta),
		.c_o        (chr_c),
		.w_o        (chr_w)
	);

	hsl_hue_mix u_hue_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_i  (chr_vld),
		.meta_i (chr_meta),
		.c_i    (chr_c),
		.w_i    (chr_w),
		.vld_o  (mix_vld),
		.meta_o (mix_meta),
		.c_o    (mix_c),
		.x_o    (mix_x)
	);

	hsl_assemble u_assemble (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld_i     (mix_vld),
		.meta_i    (mix_meta),
		.c_i       (mix_c),
		.x_i       (mix_x),
		.done      (done),
		.valid_res (valid_res),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

endmodule

`default_nettype wire

>>> sv/hsl_checker.sv
// ----------------------------------------------------------------------------
// hsl_checker
// Port-level checks for the HSL to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic [hsl_pkg::HUE_W-1:0]     hue,
	input wire logic                          done,
	input wire logic                          valid_res,
	input wire logic [hsl_pkg::FIELD_W-1:0]   red,
	input wire logic [hsl_pkg::FIELD_W-1:0]   green,
	input wire logic [hsl_pkg::FIELD_W-1:0]   blue
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	a_beat_yields_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(hsl_pkg::LATENCY) done)
		else $error("accepted beat without result");

	a_no_extra_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##(hsl_pkg::LATENCY) !done)
		else $error("result without accepted beat");

	a_hue_range_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (valid_res == ($past(hue, hsl_pkg::LATENCY) < hsl_pkg::HUE_TURN)))
		else $error("valid_res does not match hue range");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !valid_res) |-> (red == '0 && green == '0 && blue == '0))
		else $error("invalid result carries nonzero channels");

endmodule

bind hsl_to_rgb_converter hsl_checker u_hsl_checker (.*);

`default_nettype wire

>>> sim/hsl_rgb_checker.sv
// ----------------------------------------------------------------------------
// hsl_rgb_checker
// Watches the pixel and result channels of the HSL to RGB converter, works out
// the RGB value of every accepted pixel and compares it with each result beat.
// ----------------------------------------------------------------------------
module hsl_rgb_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic                        busy,
	input  wire logic [hsl_pkg::HUE_W-1:0]   hue,
	input  wire logic [hsl_pkg::FIELD_W-1:0] saturation,
	input  wire logic [hsl_pkg::FIELD_W-1:0] lightness,
	input  wire logic                        done,
	input  wire logic                        valid_res,
	input  wire logic [hsl_pkg::FIELD_W-1:0] red,
	input  wire logic [hsl_pkg::FIELD_W-1:0] green,
	input  wire logic [hsl_pkg::FIELD_W-1:0] blue,
	output int                               mismatch_cnt,
	output int                               pixels_in_flight
);
	import hsl_pkg::*;

	typedef struct packed {
		logic               ok;
		logic [FIELD_W-1:0] r;
		logic [FIELD_W-1:0] g;
		logic [FIELD_W-1:0] b;
	} rgb_pixel_t;

	rgb_pixel_t expected_rgb[$];
	int         fail_total;

	function automatic logic [63:0] clip_full(input logic [63:0] v, input logic [63:0] full);
		return (v > full) ? full : v;
	endfunction

	function automatic rgb_pixel_t rgb_from_hsl(input logic [HUE_W-1:0] h,
			input logic [FIELD_W-1:0] s_in, input logic [FIELD_W-1:0] l_in);
		logic [63:0] full, s, l, two_l, dev, chroma, q, w, x, base, lo, hi, mid;
		rgb_pixel_t  px;
		hsl_sector_t sec;
		full = (64'd1 << CHANNEL_BITS) - 64'd1;
		px = '0;
		if (h >= HUE_TURN) begin
			return px;
		end
		s = clip_full(64'(s_in), full);
		l = clip_full(64'(l_in), full);
		two_l = 2 * l;
		dev = (two_l >= full) ? two_l - full : full - two_l;
		chroma = ((full - dev) * s + (full >> 1)) / full;
		// fold hue position within a sector pair to a 0..3840 ramp
		q = 64'(h) % (2 * 64'(HUE_SECTOR));
		w = (q >= 64'(HUE_SECTOR)) ? 64'(HUE_SECTOR) - (q - 64'(HUE_SECTOR)) : q;
		x = (chroma * w + 64'(HUE_SECTOR) / 2) / 64'(HUE_SECTOR);
		base = (two_l >= chroma) ? two_l - chroma : 64'd0;
		lo = clip_full((base + 1) >> 1, full);
		hi = clip_full((two_l + chroma + 1) >> 1, full);
		mid = clip_full((base + 2 * x + 1) >> 1, full);
		sec = hsl_sector_t'(3'(h / HUE_SECTOR));
		case (sec)
			SEC_RED_YELLOW: begin
				px.r = hi[FIELD_W-1:0]; px.g = mid[FIELD_W-1:0]; px.b = lo[FIELD_W-1:0];
			end
			SEC_YELLOW_GREEN: begin
				px.r = mid[FIELD_W-1:0]; px.g = hi[FIELD_W-1:0]; px.b = lo[FIELD_W-1:0];
			end
			SEC_GREEN_CYAN: begin
				px.r = lo[FIELD_W-1:0]; px.g = hi[FIELD_W-1:0]; px.b = mid[FIELD_W-1:0];
			end
			SEC_CYAN_BLUE: begin
				px.r = lo[FIELD_W-1:0]; px.g = mid[FIELD_W-1:0]; px.b = hi[FIELD_W-1:0];
			end
			SEC_BLUE_MAGENTA: begin
				px.r = mid[FIELD_W-1:0]; px.g = lo[FIELD_W-1:0]; px.b = hi[FIELD_W-1:0];
			end
			default: begin
				px.r = hi[FIELD_W-1:0]; px.g = lo[FIELD_W-1:0]; px.b = mid[FIELD_W-1:0];
			end
		endcase
		px.ok = 1'b1;
		return px;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		rgb_pixel_t want;
		rgb_pixel_t got;
		if (!arst_n) begin
			expected_rgb.delete();
			fail_total = 0;
		end else begin
			if (start && !busy) begin
				expected_rgb.push_back(rgb_from_hsl(hue, saturation, lightness));
			end
			if (done) begin
				got = '{valid_res, red, green, blue};
				if (expected_rgb.size() == 0) begin
					fail_total++;
					if (fail_total <= 10) begin
						$display("unexpected result beat: valid=%0d rgb=%h %h %h",
							got.ok, got.r, got.g, got.b);
					end
				end else begin
					want = expected_rgb.pop_front();
					if (got.ok !== want.ok || got.r !== want.r || got.g !== want.g ||
							got.b !== want.b) begin
						fail_total++;
						if (fail_total <= 10) begin
							$display({"result mismatch: exp valid=%0d rgb=%h %h %h, ",
								"got valid=%0d rgb=%h %h %h"},
								want.ok, want.r, want.g, want.b,
								got.ok, got.r, got.g, got.b);
						end
					end
				end
			end
		end
		mismatch_cnt <= fail_total;
		pixels_in_flight <= expected_rgb.size();
	end

endmodule

>>> sim/hsl_to_rgb_converter_tb.sv
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter_tb
// Drives directed and random HSL pixels into the converter under varying
// sender gaps; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter_tb;
	import hsl_pkg::*;

	localparam int STALL_LIMIT = 1000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [HUE_W-1:0]   hue;
	logic [FIELD_W-1:0] saturation;
	logic [FIELD_W-1:0] lightness;
	logic               done;
	logic               valid_res;
	logic [FIELD_W-1:0] red;
	logic [FIELD_W-1:0] green;
	logic [FIELD_W-1:0] blue;
	int                 mismatch_cnt;
	int                 pixels_in_flight;
	int                 gap_pct;
	int                 stall_cycles;

	hsl_to_rgb_converter dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.hue(hue), .saturation(saturation), .lightness(lightness),
		.done(done), .valid_res(valid_res), .red(red), .green(green), .blue(blue)
	);

	hsl_rgb_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.hue(hue), .saturation(saturation), .lightness(lightness),
		.done(done), .valid_res(valid_res), .red(red), .green(green), .blue(blue),
		.mismatch_cnt(mismatch_cnt), .pixels_in_flight(pixels_in_flight)
	);

	always #1 clk = ~clk;

	// ends the run if neither channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic send_pixel(input logic [HUE_W-1:0] h, input logic [FIELD_W-1:0] s,
			input logic [FIELD_W-1:0] l);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		hue <= h;
		saturation <= s;
		lightness <= l;
		do @(posedge clk); while (busy);
	endtask

	function automatic logic [FIELD_W-1:0] pick_frac();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return 16'd32767 + 16'($urandom_range(1));
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	function automatic logic [HUE_W-1:0] pick_hue();
		case ($urandom_range(9))
			0: return 16'($urandom_range(65535, 23040));
			// around a sector boundary
			1: return 16'($urandom_range(5) * 3840 + $urandom_range(2));
			2: return 16'(23039 - $urandom_range(3));
			default: return 16'($urandom_range(23039));
		endcase
	endfunction

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		hue <= '0;
		saturation <= '0;
		lightness <= '0;
		gap_pct = 6;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sector boundaries and midpoints, mostly at full saturation, half lightness
		send_pixel(16'd0, 16'hFFFF, 16'd32768);
		send_pixel(16'd1920, 16'hFFFF, 16'd32767);
		send_pixel(16'd3839, 16'hFFFF, 16'd32768);
		send_pixel(16'd3840, 16'hFFFF, 16'd32768);
		send_pixel(16'd5760, 16'hFFFF, 16'd32768);
		send_pixel(16'd7679, 16'hFFFF, 16'd32768);
		send_pixel(16'd7680, 16'hFFFF, 16'd32767);
		send_pixel(16'd11520, 16'hFFFF, 16'd32768);
		send_pixel(16'd13440, 16'hC000, 16'd20000);
		send_pixel(16'd15360, 16'hFFFF, 16'd32768);
		send_pixel(16'd17280, 16'h8000, 16'd45000);
		send_pixel(16'd19200, 16'hFFFF, 16'd32768);
		send_pixel(16'd21120, 16'hFFFF, 16'd32768);
		send_pixel(16'd23039, 16'hFFFF, 16'd32768);
		// hue out of range
		send_pixel(16'd23040, 16'hFFFF, 16'd32768);
		send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_pixel(16'h8000, 16'h1234, 16'h5678);
		// grey, black, white and extremes
		send_pixel(16'd5000, 16'd0, 16'd30000);
		send_pixel(16'd9000, 16'hFFFF, 16'd0);
		send_pixel(16'd9000, 16'hFFFF, 16'hFFFF);
		send_pixel(16'd0, 16'd0, 16'd0);
		send_pixel(16'd12000, 16'd1, 16'd1);
		send_pixel(16'd12001, 16'hFFFE, 16'hFFFE);

		for (int phase = 0; phase < 3; phase++) begin
			gap_pct = (phase == 0) ? 6 : (phase == 1) ? 81 : 0;
			repeat (400) send_pixel(pick_hue(), pick_frac(), pick_frac());
		end
		start <= 1'b0;

		@(posedge clk);
		wait (pixels_in_flight == 0);
		repeat (LATENCY + 5) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
